[rtl/address_lease_table_defines.svh]
// assertion macros for the address lease table rtl
// no dependencies; included by files that carry assertions
`ifndef ADDRESS_LEASE_TABLE_DEFINES_SVH
`define ADDRESS_LEASE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ALT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lease table check failed");

// next-cycle implication, disabled while in reset
`define ALT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lease table check failed");

`endif

[rtl/alt_pkg.sv]
// shared types and constants for the address lease table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package alt_pkg;

  // lease record table
  localparam int RECORDS = 4;
  localparam int IDX_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int MAC_W   = 48;
  localparam int OCTET_W = 8;
  localparam int CAND_W  = OCTET_W + 1;
  localparam int BASE_W  = 24;
  localparam int ADDR_W  = BASE_W + OCTET_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_BASE = 2'd2;

  // configuration reset values
  localparam logic [OCTET_W-1:0] RANGE_LOW_RST  = 8'd80;
  localparam logic [OCTET_W-1:0] RANGE_HIGH_RST = 8'd89;
  localparam logic [BASE_W-1:0]  SUBNET_RST     = 24'd0;

  // result status codes
  localparam logic [1:0] STAT_EXISTING = 2'd0;
  localparam logic [1:0] STAT_NEW      = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // sequencer to record store
  typedef struct packed {
    logic [IDX_W-1:0]   rd_idx;
    logic [OCTET_W-1:0] probe;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [MAC_W-1:0]   wr_mac;
    logic [OCTET_W-1:0] wr_host;
    logic               clr;
  } store_cmd_t;

  // record store to sequencer
  typedef struct packed {
    logic               valid;
    logic [MAC_W-1:0]   mac;
    logic [OCTET_W-1:0] host;
    logic               in_use;
  } store_rd_t;

  // finished lease from the sequencer
  typedef struct packed {
    logic [1:0]         status;
    logic [OCTET_W-1:0] octet;
  } res_t;

endpackage

`default_nettype wire

[rtl/alt_store.sv]
// lease record store: valid bits, mac and host octet per record
// depends on alt_pkg for widths and the command and read structs
`timescale 1ns / 1ps
`default_nettype none

module alt_store (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire alt_pkg::store_cmd_t cmd,
  output alt_pkg::store_rd_t       rd
);
  import alt_pkg::*;

  logic [RECORDS-1:0]  valid_r;
  logic [MAC_W-1:0]    mac_r  [RECORDS];
  logic [OCTET_W-1:0]  host_r [RECORDS];
  logic [RECORDS-1:0]  hit_vec;

  // valid bits: cleared by reset and by a pool-empty flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[cmd.wr_idx] <= 1'b1;
    end
  end

  // record payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mac_r[cmd.wr_idx]  <= cmd.wr_mac;
      host_r[cmd.wr_idx] <= cmd.wr_host;
    end
  end

  // per-record octet compare for the candidate probe
  always_comb begin
    for (int j = 0; j < RECORDS; j++) begin
      hit_vec[j] = valid_r[j] && (host_r[j] == cmd.probe);
    end
  end

  // scan read port
  assign rd.valid  = valid_r[cmd.rd_idx];
  assign rd.mac    = mac_r[cmd.rd_idx];
  assign rd.host   = host_r[cmd.rd_idx];
  assign rd.in_use = |hit_vec;

endmodule

`default_nettype wire

[rtl/alt_ctrl.sv]
// lease sequencer: record scan with one mac compare, then octet search
// depends on alt_pkg and address_lease_table_defines.svh; drives alt_store and hands results to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "address_lease_table_defines.svh"

module alt_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [alt_pkg::MAC_W-1:0]    in_client_mac,
  input  wire  [alt_pkg::OCTET_W-1:0]  range_low,
  input  wire  [alt_pkg::OCTET_W-1:0]  range_high,
  output alt_pkg::store_cmd_t          cmd,
  input  wire  alt_pkg::store_rd_t     rd,
  output logic                         res_valid,
  input  wire                          res_take,
  output alt_pkg::res_t                res
);
  import alt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_SEARCH, ST_EMIT} state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    idx_r;
  logic [MAC_W-1:0]    mac_r;
  logic                hit_r;
  logic                slot_found_r;
  logic [IDX_W-1:0]    slot_r;
  logic [CAND_W-1:0]   cand_r;
  logic [1:0]          status_r;
  logic [OCTET_W-1:0]  octet_r;

  logic                match;
  logic                last_rec;
  logic                hit_nxt;
  logic                slot_found_nxt;
  logic                cand_over;
  logic                cand_free;

  // shared mac compare and scan bookkeeping
  assign match          = rd.valid && (rd.mac == mac_r);
  assign last_rec       = (idx_r == IDX_W'(RECORDS - 1));
  assign hit_nxt        = hit_r || match;
  assign slot_found_nxt = slot_found_r || !rd.valid;

  // candidate octet checks
  assign cand_over = (cand_r > {1'b0, range_high});
  assign cand_free = !cand_over && !rd.in_use;

  // store commands
  always_comb begin
    cmd.rd_idx  = idx_r;
    cmd.probe   = cand_r[OCTET_W-1:0];
    cmd.wr_en   = (state_r == ST_SEARCH) && cand_free;
    cmd.wr_idx  = slot_r;
    cmd.wr_mac  = mac_r;
    cmd.wr_host = cand_r[OCTET_W-1:0];
    cmd.clr     = (state_r == ST_SEARCH) && cand_over;
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_EMIT);
  assign res.status = status_r;
  assign res.octet  = octet_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hit_r        <= 1'b0;
      slot_found_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mac_r        <= in_client_mac;
            idx_r        <= '0;
            hit_r        <= 1'b0;
            slot_found_r <= 1'b0;
            state_r      <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          // last matching record wins, first free record is kept
          if (match) begin
            hit_r   <= 1'b1;
            octet_r <= rd.host;
          end
          if (!rd.valid && !slot_found_r) begin
            slot_r       <= idx_r;
            slot_found_r <= 1'b1;
          end
          idx_r <= idx_r + IDX_W'(1);
          if (last_rec) begin
            if (hit_nxt) begin
              status_r <= STAT_EXISTING;
              state_r  <= ST_EMIT;
            end else if (!slot_found_nxt) begin
              status_r <= STAT_FULL;
              octet_r  <= '0;
              state_r  <= ST_EMIT;
            end else begin
              // octet zero is never handed out
              cand_r  <= (range_low == '0) ? CAND_W'(1) : {1'b0, range_low};
              state_r <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (cand_over) begin
            status_r <= STAT_EMPTY;
            octet_r  <= '0;
            state_r  <= ST_EMIT;
          end else if (!rd.in_use) begin
            status_r <= STAT_NEW;
            octet_r  <= cand_r[OCTET_W-1:0];
            state_r  <= ST_EMIT;
          end else begin
            cand_r <= cand_r + CAND_W'(1);
          end
        end
        ST_EMIT: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a record write always ends in a new lease
  `ALT_ASSERT_NEXT(a_wr_new, clk, rst_n, cmd.wr_en, (state_r == ST_EMIT) && (status_r == STAT_NEW))
  // a flush always ends in a pool-empty result
  `ALT_ASSERT_NEXT(a_clr_empty, clk, rst_n, cmd.clr, (state_r == ST_EMIT) && (status_r == STAT_EMPTY))
  // the octet search never probes octet zero
  `ALT_ASSERT_NOW(a_cand_nonzero, clk, rst_n, state_r == ST_SEARCH, cand_r != '0)

endmodule

`default_nettype wire

[rtl/address_lease_table.sv]
// address lease table top level: config registers, output register, glue
// depends on alt_pkg, alt_store and alt_ctrl
//
//   channel | direction | payload                                   | handshake
//   in      | input     | in_client_mac[47:0]                       | in_valid / in_ready
//   out     | output    | out_status, out_host_octet, out_client_address | out_valid / out_ready
//   cfg     | input     | cfg_index[1:0], cfg_data[23:0]            | cfg_valid / cfg_ready
//
// one item at a time; the record scan takes one record per cycle and the
// octet search one candidate per cycle through the per-record octet compare
// existing lease or table full: result registered after the record scan alone
// new lease or pool empty: result registered after the record scan and the octet search
// reset clears valid bits at once; no clearing pass, cfg_ready is always high
// a stalled result holds the sequencer; in_ready rises once it is taken
`timescale 1ns / 1ps
`default_nettype none

module address_lease_table (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [alt_pkg::MAC_W-1:0]      in_client_mac,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [1:0]                     out_status,
  output logic [alt_pkg::OCTET_W-1:0]    out_host_octet,
  output logic [alt_pkg::ADDR_W-1:0]     out_client_address,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [alt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [alt_pkg::BASE_W-1:0]     cfg_data
);
  import alt_pkg::*;

  logic [OCTET_W-1:0] range_low_r;
  logic [OCTET_W-1:0] range_high_r;
  logic [BASE_W-1:0]  subnet_base_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [OCTET_W-1:0] out_octet_r;
  logic [ADDR_W-1:0]  out_addr_r;

  store_cmd_t cmd;
  store_rd_t  rd;
  res_t       res;
  logic       res_valid;
  logic       res_take;
  logic       res_fail;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= RANGE_LOW_RST;
      range_high_r  <= RANGE_HIGH_RST;
      subnet_base_r <= SUBNET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RANGE_LOW:   range_low_r   <= cfg_data[OCTET_W-1:0];
        CFG_RANGE_HIGH:  range_high_r  <= cfg_data[OCTET_W-1:0];
        CFG_SUBNET_BASE: subnet_base_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  alt_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rd    (rd)
  );

  alt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_client_mac (in_client_mac),
    .range_low     (range_low_r),
    .range_high    (range_high_r),
    .cmd           (cmd),
    .rd            (rd),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  // output register, loads when empty or drained this cycle
  assign res_take = !out_valid_r || out_ready;
  assign res_fail = (res.status == STAT_EMPTY) || (res.status == STAT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload; address is subnet base above the host octet, zero on pool empty or table full
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_status_r <= res.status;
      out_octet_r  <= res.octet;
      out_addr_r   <= res_fail ? '0 : {subnet_base_r, res.octet};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_host_octet     = out_octet_r;
  assign out_client_address = out_addr_r;

endmodule

`default_nettype wire
